// ----- rtl/vt_escape_sequence_parser_core_assert.svh -----
// Assertion macros for the escape-sequence parser checker.
`ifndef VT_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH
`define VT_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define VTP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication checked in the next cycle.
`define VTP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/vtp_pkg.sv -----
// ----------------------------------------------------------------------------
// vtp_pkg
// Types, codes and constants of the escape-sequence parser.
// ----------------------------------------------------------------------------
package vtp_pkg;
  localparam int MAX_INTER_DEF  = 2;
  localparam int MAX_PARAMS_DEF = 16;

  typedef enum logic [3:0] {
    S_GROUND = 4'd0, S_ESC = 4'd1, S_ESC_INT = 4'd2, S_CSI_ENTRY = 4'd3,
    S_CSI_IGN = 4'd4, S_CSI_PARAM = 4'd5, S_CSI_INT = 4'd6, S_DCS_ENTRY = 4'd7,
    S_DCS_INT = 4'd8, S_DCS_IGN = 4'd9, S_DCS_PARAM = 4'd10, S_DCS_PASS = 4'd11,
    S_SOS = 4'd12, S_OSC = 4'd13, S_BAD = 4'd14, S_NONE = 4'd15
  } pstate_t;

  typedef enum logic [3:0] {
    A_PRINT = 4'd0, A_EXEC = 4'd1, A_HOOK = 4'd2, A_PUT = 4'd3,
    A_OSC_START = 4'd4, A_OSC_PUT = 4'd5, A_OSC_END = 4'd6, A_UNHOOK = 4'd7,
    A_CSI = 4'd8, A_ESC = 4'd9, A_IGNORE = 4'd10, A_COLLECT = 4'd11,
    A_PARAM = 4'd12, A_CLEAR = 4'd13, A_NONE = 4'd14
  } act_t;

  // controller phases: idle, exit action, transition action, entry action, parameter run, closing wait
  typedef enum logic [2:0] {
    C_IDLE, C_EXIT, C_TRANS, C_ENTRY, C_RUN, C_WAIT
  } cstate_t;

  typedef struct packed {
    act_t    act;
    pstate_t nxt;
  } lk_t;

  // command from controller to datapath
  typedef struct packed {
    logic       take;      // latch input byte
    logic       do_act;    // run internal action (collect/param/clear)
    act_t       act;
    logic [7:0] b;         // byte for emitted results and for collect/param actions
    logic       emit;      // load output register
    logic       run_first; // start a parameter run at index 0
    logic       run_next;  // advance run index
    logic       is_last;
  } cmd_t;

  typedef struct packed {
    logic run_end;   // current index is the final one of the run
    logic out_busy;  // output register full and not taken
  } sts_t;

  function automatic lk_t lookup(pstate_t st, logic [7:0] b);
    lk_t r;
    logic c0, inter, digit, priv, fin, csi;
    c0 = b < 8'h20;
    inter = b >= 8'h20 && b <= 8'h2f;
    digit = (b >= 8'h30 && b <= 8'h39) || b == 8'h3b;
    priv = b >= 8'h3c && b <= 8'h3f;
    fin = b >= 8'h40 && b <= 8'h7e;
    csi = st == S_CSI_ENTRY || st == S_CSI_PARAM || st == S_CSI_INT;
    r = '{A_NONE, S_NONE};
    if (b >= 8'ha0) return r;
    if (b == 8'h18 || b == 8'h1a || (b >= 8'h80 && b <= 8'h8f) ||
        (b >= 8'h91 && b <= 8'h97) || b == 8'h99 || b == 8'h9a) return '{A_EXEC, S_GROUND};
    if (b == 8'h9c) return '{A_NONE, S_GROUND};
    if (b == 8'h1b) return '{A_NONE, S_ESC};
    if (b == 8'h98 || b == 8'h9e || b == 8'h9f) return '{A_NONE, S_SOS};
    if (b == 8'h90) return '{A_NONE, S_DCS_ENTRY};
    if (b == 8'h9d) return '{A_NONE, S_OSC};
    if (b == 8'h9b) return '{A_NONE, S_CSI_ENTRY};
    case (st)
      S_GROUND: r = '{c0 ? A_EXEC : A_PRINT, S_NONE};
      S_ESC: begin
        if (c0) r = '{A_EXEC, S_NONE};
        else if (b == 8'h7f) r = '{A_IGNORE, S_NONE};
        else if (inter) r = '{A_COLLECT, S_ESC_INT};
        else if (b == 8'h5b) r = '{A_NONE, S_CSI_ENTRY};
        else if (b == 8'h5d) r = '{A_NONE, S_OSC};
        else if (b == 8'h50) r = '{A_NONE, S_DCS_ENTRY};
        else if (b == 8'h58 || b == 8'h5e || b == 8'h5f) r = '{A_NONE, S_SOS};
        else r = '{A_ESC, S_GROUND};
      end
      S_ESC_INT: begin
        if (c0) r = '{A_EXEC, S_NONE};
        else if (inter) r = '{A_COLLECT, S_NONE};
        else if (b == 8'h7f) r = '{A_IGNORE, S_NONE};
        else r = '{A_ESC, S_GROUND};
      end
      S_CSI_ENTRY, S_DCS_ENTRY: begin
        if (c0 || b == 8'h7f) r = '{(csi && c0) ? A_EXEC : A_IGNORE, S_NONE};
        else if (inter) r = '{A_COLLECT, csi ? S_CSI_INT : S_DCS_INT};
        else if (b == 8'h3a) r = '{A_NONE, csi ? S_CSI_IGN : S_DCS_IGN};
        else if (digit) r = '{A_PARAM, csi ? S_CSI_PARAM : S_DCS_PARAM};
        else if (priv) r = '{A_COLLECT, csi ? S_CSI_PARAM : S_DCS_PARAM};
        else if (csi) r = '{A_CSI, S_GROUND};
        else r = '{A_NONE, S_DCS_PASS};
      end
      S_CSI_IGN: begin
        if (c0) r = '{A_EXEC, S_NONE};
        else if (fin) r = '{A_NONE, S_GROUND};
        else r = '{A_IGNORE, S_NONE};
      end
      S_CSI_PARAM, S_DCS_PARAM: begin
        if (c0 || b == 8'h7f) r = '{(csi && c0) ? A_EXEC : A_IGNORE, S_NONE};
        else if (digit) r = '{A_PARAM, S_NONE};
        else if (b == 8'h3a || priv) r = '{A_NONE, csi ? S_CSI_IGN : S_DCS_IGN};
        else if (inter) r = '{A_COLLECT, csi ? S_CSI_INT : S_DCS_INT};
        else if (csi) r = '{A_CSI, S_GROUND};
        else r = '{A_NONE, S_DCS_PASS};
      end
      S_CSI_INT, S_DCS_INT: begin
        if (c0 || b == 8'h7f) r = '{(csi && c0) ? A_EXEC : A_IGNORE, S_NONE};
        else if (inter) r = '{A_COLLECT, S_NONE};
        else if (!fin) r = '{A_NONE, csi ? S_CSI_IGN : S_DCS_IGN};
        else if (csi) r = '{A_CSI, S_GROUND};
        else r = '{A_NONE, S_DCS_PASS};
      end
      S_DCS_IGN, S_SOS: r = '{A_IGNORE, S_NONE};
      S_DCS_PASS: r = '{b == 8'h7f ? A_IGNORE : A_PUT, S_NONE};
      S_OSC: r = '{c0 ? A_IGNORE : A_OSC_PUT, S_NONE};
      default: r = '{A_NONE, S_NONE};
    endcase
    return r;
  endfunction

  function automatic act_t entry_act(pstate_t st);
    case (st)
      S_ESC, S_CSI_ENTRY, S_DCS_ENTRY: return A_CLEAR;
      S_DCS_PASS: return A_HOOK;
      S_OSC: return A_OSC_START;
      default: return A_NONE;
    endcase
  endfunction

  function automatic act_t exit_act(pstate_t st);
    case (st)
      S_DCS_PASS: return A_UNHOOK;
      S_OSC: return A_OSC_END;
      default: return A_NONE;
    endcase
  endfunction

  // actions that give a result item
  function automatic logic is_emit(act_t a);
    return a <= A_ESC;
  endfunction

  function automatic logic is_run(act_t a);
    return a == A_HOOK || a == A_CSI || a == A_ESC;
  endfunction
endpackage

// ----- rtl/vtp_if.sv -----
// ----------------------------------------------------------------------------
// vtp_in_if / vtp_out_if
// Valid/ready channels for terminal bytes and parser result items.
// ----------------------------------------------------------------------------
interface vtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface vtp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action_code;
  logic [7:0]  byte_out;
  logic [4:0]  param_count;
  logic [3:0]  param_index;
  logic [15:0] param_value;
  logic [1:0]  inter_count;
  logic [7:0]  inter_first;
  logic [7:0]  inter_second;
  logic        overflow_flag;
  logic        last;
  modport source (output valid, output action_code, output byte_out, output param_count,
                  output param_index, output param_value, output inter_count,
                  output inter_first, output inter_second, output overflow_flag,
                  output last, input ready);
  modport sink (input valid, input action_code, input byte_out, input param_count,
                input param_index, input param_value, input inter_count,
                input inter_first, input inter_second, input overflow_flag,
                input last, output ready);
endinterface

// ----- rtl/vtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// vtp_ctrl
// Sequencer: exit, transition and entry actions, and parameter runs.
// ----------------------------------------------------------------------------
module vtp_ctrl
  import vtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  sts_t       sts,
  output cmd_t       cmd
);
  cstate_t cs_r, cs_nxt;
  pstate_t ps_r, ps_nxt;
  lk_t     lk_r, lk_nxt;
  logic [7:0] b_r, b_nxt;
  act_t    run_act_r, run_act_nxt;
  logic    run_last_r, run_last_nxt;

  lk_t  lk_now;
  act_t ex_a, tr_a, en_a;
  logic moved;

  assign lk_now = lookup(ps_r, in_byte);
  assign moved  = lk_r.nxt != S_NONE;
  assign ex_a   = moved ? exit_act(ps_r) : A_NONE;
  assign tr_a   = lk_r.act;
  assign en_a   = moved ? entry_act(lk_r.nxt) : A_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= C_IDLE;
      ps_r <= S_GROUND;
    end else begin
      cs_r <= cs_nxt;
      ps_r <= ps_nxt;
    end
    lk_r <= lk_nxt;
    b_r <= b_nxt;
    run_act_r <= run_act_nxt;
    run_last_r <= run_last_nxt;
  end

  // next state
  always_comb begin
    cs_nxt = cs_r;
    ps_nxt = ps_r;
    lk_nxt = lk_r;
    b_nxt = b_r;
    run_act_nxt = run_act_r;
    run_last_nxt = run_last_r;
    case (cs_r)
      C_IDLE: if (in_valid) begin
        lk_nxt = lk_now;
        b_nxt = in_byte;
        cs_nxt = C_EXIT;
      end
      C_EXIT: if (!(is_emit(ex_a) && sts.out_busy)) cs_nxt = C_TRANS;
      C_TRANS: begin
        if (is_run(tr_a)) begin
          if (!sts.out_busy) begin
            run_act_nxt = tr_a;
            run_last_nxt = !is_emit(en_a);
            cs_nxt = sts.run_end ? C_ENTRY : C_RUN;
          end
        end else if (!(is_emit(tr_a) && sts.out_busy)) cs_nxt = C_ENTRY;
      end
      C_RUN: if (!sts.out_busy && sts.run_end) cs_nxt = run_act_r == tr_a ? C_ENTRY : C_WAIT;
      C_ENTRY: begin
        if (is_run(en_a)) begin
          if (!sts.out_busy) begin
            run_act_nxt = en_a;
            run_last_nxt = 1'b1;
            cs_nxt = sts.run_end ? C_WAIT : C_RUN;
          end
        end else if (!(is_emit(en_a) && sts.out_busy)) cs_nxt = C_WAIT;
        if (cs_nxt != C_ENTRY && cs_nxt != C_RUN && moved) ps_nxt = lk_r.nxt;
      end
      C_WAIT: cs_nxt = C_IDLE;
      default: cs_nxt = C_IDLE;
    endcase
    if (cs_r == C_RUN && cs_nxt == C_WAIT && moved) ps_nxt = lk_r.nxt;
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.act = A_NONE;
    in_ready = cs_r == C_IDLE;
    case (cs_r)
      C_EXIT: begin
        cmd.act = ex_a;
        cmd.emit = is_emit(ex_a) && !sts.out_busy;
        cmd.is_last = !is_emit(tr_a) && !is_emit(en_a);
      end
      C_TRANS: begin
        cmd.act = tr_a;
        cmd.b = b_r;
        cmd.do_act = !is_emit(tr_a);
        cmd.emit = is_emit(tr_a) && !sts.out_busy;
        cmd.run_first = is_run(tr_a) && !sts.out_busy;
        cmd.is_last = !is_emit(en_a) && (!is_run(tr_a) || sts.run_end);
      end
      C_RUN: begin
        cmd.act = run_act_r;
        cmd.b = run_act_r == tr_a ? b_r : 8'h00;
        cmd.emit = !sts.out_busy;
        cmd.run_next = !sts.out_busy;
        cmd.is_last = run_last_r && sts.run_end;
      end
      C_ENTRY: begin
        cmd.act = en_a;
        cmd.do_act = !is_emit(en_a);
        cmd.emit = is_emit(en_a) && !sts.out_busy;
        cmd.run_first = is_run(en_a) && !sts.out_busy;
        cmd.is_last = !is_run(en_a) || sts.run_end;
      end
      default: ;
    endcase
    cmd.take = 1'b0;
  end
endmodule

// ----- rtl/vtp_dp.sv -----
// ----------------------------------------------------------------------------
// vtp_dp
// Parameter and intermediate stores, run index and output register.
// ----------------------------------------------------------------------------
module vtp_dp
  import vtp_pkg::*;
#(
  parameter int MAX_INTER  = MAX_INTER_DEF,
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  vtp_out_if.source out_ch
);
  localparam int PW = $clog2(MAX_PARAMS + 1);
  localparam int PI = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int IW = $clog2(MAX_INTER + 1);
  localparam int II = (MAX_INTER > 1) ? $clog2(MAX_INTER) : 1;

  logic [15:0] pst_r [MAX_PARAMS];
  logic [7:0]  ist_r [MAX_INTER];
  logic [PW-1:0] pt_r, pt_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic ov_r, ov_nxt;
  logic [PW-1:0] ri_r, ri_nxt;
  logic vld_r;
  logic [3:0] o_act_r;
  logic [7:0] o_b_r, o_i1_r, o_i2_r;
  logic [4:0] o_pc_r;
  logic [3:0] o_pi_r;
  logic [15:0] o_pv_r;
  logic [1:0] o_ic_r;
  logic o_ov_r, o_last_r;

  logic [PW-1:0] idx;
  logic [PI-1:0] wa;
  logic [19:0] prod;
  logic        wr;
  logic [15:0] wd;

  // index of the parameter emitted this cycle
  assign idx = cmd.run_first ? '0 : ri_r;
  assign sts.run_end = (pt_r == '0) || (idx + 1'b1 >= pt_r);
  assign sts.out_busy = vld_r && !out_ch.ready;

  always_comb begin
    pt_nxt = pt_r;
    it_nxt = it_r;
    ov_nxt = ov_r;
    wr = 1'b0;
    wa = '0;
    wd = '0;
    prod = '0;
    if (cmd.do_act) begin
      case (cmd.act)
        A_COLLECT: begin
          if (it_r >= IW'(MAX_INTER)) ov_nxt = 1'b1;
          else it_nxt = it_r + 1'b1;
        end
        A_PARAM: begin
          if (cmd.b == 8'h3b) begin
            if (pt_r < PW'(MAX_PARAMS)) begin
              wr = 1'b1;
              wa = PI'(pt_r);
              pt_nxt = pt_r + 1'b1;
            end
          end else begin
            wr = 1'b1;
            if (pt_r == '0) begin
              pt_nxt = PW'(1);
              prod = {16'd0, cmd.b[3:0]};
            end else begin
              wa = PI'(pt_r - 1'b1);
              prod = {pst_r[wa], 3'b000} + {2'b00, pst_r[wa], 1'b0} + {16'd0, cmd.b[3:0]};
            end
            wd = (prod > 20'd65535) ? 16'hffff : prod[15:0];
          end
        end
        A_CLEAR: begin
          pt_nxt = '0;
          it_nxt = '0;
          ov_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    ri_nxt = ri_r;
    if (cmd.run_first) ri_nxt = PW'(1);
    else if (cmd.run_next) ri_nxt = ri_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
      it_r <= '0;
      ov_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      pt_r <= pt_nxt;
      it_r <= it_nxt;
      ov_r <= ov_nxt;
      if (cmd.emit) vld_r <= 1'b1;
      else if (out_ch.ready) vld_r <= 1'b0;
    end
    ri_r <= ri_nxt;
    if (wr) pst_r[wa] <= wd;
    if (cmd.do_act && cmd.act == A_COLLECT && it_r < IW'(MAX_INTER))
      ist_r[II'(it_r)] <= cmd.b;
    if (cmd.emit) begin
      o_act_r <= cmd.act;
      o_b_r <= cmd.b;
      o_pc_r <= 5'(pt_r);
      o_last_r <= cmd.is_last;
      o_ov_r <= ov_r;
      o_ic_r <= (it_r > IW'(3)) ? 2'd3 : 2'(it_r);
      o_i1_r <= (it_r >= IW'(1)) ? ist_r[0] : 8'h00;
      o_i2_r <= (it_r >= IW'(2) && MAX_INTER >= 2) ? ist_r[1 % MAX_INTER] : 8'h00;
      if (is_run(act_t'(cmd.act)) && pt_r != '0) begin
        o_pi_r <= 4'(idx);
        o_pv_r <= pst_r[PI'(idx)];
      end else begin
        o_pi_r <= 4'd0;
        o_pv_r <= 16'd0;
      end
    end
  end

  assign out_ch.valid = vld_r;
  assign out_ch.action_code = o_act_r;
  assign out_ch.byte_out = o_b_r;
  assign out_ch.param_count = o_pc_r;
  assign out_ch.param_index = o_pi_r;
  assign out_ch.param_value = o_pv_r;
  assign out_ch.inter_count = o_ic_r;
  assign out_ch.inter_first = o_i1_r;
  assign out_ch.inter_second = o_i2_r;
  assign out_ch.overflow_flag = o_ov_r;
  assign out_ch.last = o_last_r;
endmodule

// ----- rtl/vt_escape_sequence_parser_core.sv -----
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_core
// DEC/ANSI escape-sequence parser, one terminal byte per input item.
// ----------------------------------------------------------------------------
// in_ch carries raw terminal bytes; out_ch carries parser events (print,
// execute, put, OSC, hook/unhook, dispatch). Dispatch and hook give one
// result item per stored parameter, or a single item when none is stored;
// last marks the final item of a byte. Each byte walks the sequencer
// through exit, transition and entry phases and a closing wait phase; a
// parameter run adds a run phase that gives the items for the parameters
// beyond the first. The sequencer phases are in vtp_ctrl.
// The first result is registered in the exit phase when it comes from an
// exit action, in the transition phase when it comes from a transition
// action and in the entry phase when it comes from an entry action.
// Results sit in an output register; a stall there holds the sequencer in
// its phase until the register is taken. A byte with no result still takes
// the full phase walk.
// Reset puts the parser in the ground state with no parameters or
// intermediates collected; the output register comes up empty.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser_core
  import vtp_pkg::*;
#(
  parameter int MAX_INTER  = MAX_INTER_DEF,
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input logic clk,
  input logic rst_n,
  vtp_in_if.sink    in_ch,
  vtp_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  vtp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.byte_in), .sts(sts), .cmd(cmd)
  );

  vtp_dp #(.MAX_INTER(MAX_INTER), .MAX_PARAMS(MAX_PARAMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .out_ch(out_ch)
  );
endmodule

// ----- rtl/vtp_checker.sv -----
// ----------------------------------------------------------------------------
// vtp_checker
// Port-level checks on the parser's result channel and its input ready.
// ----------------------------------------------------------------------------
`include "vt_escape_sequence_parser_core_assert.svh"
module vtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  action_code,
  input logic [3:0]  param_index,
  input logic [15:0] param_value,
  input logic [4:0]  param_count,
  input logic        last
);
  `VTP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action_code))
  `VTP_ASSERT_IMP(a_code, clk, rst_n, out_valid, action_code <= 4'd9)
  `VTP_ASSERT_IMP(a_idx, clk, rst_n, out_valid && param_count == 5'd0,
    param_index == 4'd0 && param_value == 16'd0)
  `VTP_ASSERT_IMP(a_busy, clk, rst_n, out_valid && !last, !in_ready)
endmodule

bind vt_escape_sequence_parser_core vtp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .action_code(out_ch.action_code),
  .param_index(out_ch.param_index), .param_value(out_ch.param_value),
  .param_count(out_ch.param_count), .last(out_ch.last)
);
